@@ src/hps_pkg.sv @@
package hps_pkg;

    localparam int TEXT_DEPTH  = 65536;
    localparam int SYMBOL_BITS = 8;
    localparam int MAX_PATTERN = 64;

    localparam int TEXT_AW   = $clog2(TEXT_DEPTH);
    localparam int PAT_AW    = $clog2(MAX_PATTERN);
    localparam int SHIFT_AW  = 8;
    localparam int SHIFT_N   = 256;
    localparam int PLEN_W    = 7;
    localparam int TLEN_W    = 17;
    localparam int POS_W     = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        REQ_TEXT    = 2'd0,
        REQ_PATTERN = 2'd1,
        REQ_SEARCH  = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

endpackage

@@ src/hps_ram.sv @@
module hps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/horspool_packed_text_search.sv @@
// Horspool text search over a stored text of mapped symbols.
// Input items arrive on the s_ stream; s_tuser carries the request kind.
// A text or pattern write is taken while idle and gives no result.
// A search item holds the input side while it runs: the shift table is
// first filled with the pattern length in all 256 entries, then the
// pattern symbols below the last are folded in. The scan then passes
// through S_CHECK and S_CMP per symbol compare and S_TK and S_SH per
// window shift, all bound by the single read port of the text memory.
// A search with a bad pattern length skips the table and scan and goes to S_RES.
// Each search gives one result item on the m_ stream from an output register;
// writes keep being accepted while that result waits, and a later search
// waits at its end until the receiver has taken the earlier result.
// text_length is written on the cfg_ channel, which is always ready.
// Reset (aresetn low, synchronous) clears the control state, the pending
// result and text_length; memory contents are left as they are.
module horspool_packed_text_search (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hps_pkg::TLEN_W-1:0]     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // index[15:0], symbol[23:16], pattern_length[30:24], start_position[46:31]
    input  logic [hps_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // match_position[15:0], found[16], bad_length[17]
    output logic [hps_pkg::OUT_DATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_FILL, S_BUILD, S_CHECK, S_CMP, S_TK, S_SH, S_RES
    } state_t;

    localparam int TAW = hps_pkg::TEXT_AW;
    localparam int PAW = hps_pkg::PAT_AW;
    localparam int SAW = hps_pkg::SHIFT_AW;
    localparam int SB  = hps_pkg::SYMBOL_BITS;
    localparam int PW  = hps_pkg::PLEN_W;
    localparam int TW  = hps_pkg::TLEN_W;
    localparam int QW  = hps_pkg::POS_W;

    state_t state_reg, state_next;
    logic [TW-1:0]  text_length_reg;
    logic [PW-1:0]  plen_reg, plen_next;
    logic [TW-1:0]  k_reg, k_next;
    logic [PAW-1:0] j_reg, j_next;
    logic [SAW-1:0] fill_reg, fill_next;
    logic [PW-1:0]  bld_idx_reg, bld_idx_next;
    logic           bld_wr_reg, bld_wr_next;
    logic [PW-1:0]  bld_val_reg, bld_val_next;
    logic [QW-1:0]  rpos_reg, rpos_next;
    logic           rfound_reg, rfound_next;
    logic           rbad_reg, rbad_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [QW-1:0]  m_pos_reg, m_pos_next;
    logic           m_found_reg, m_found_next;
    logic           m_bad_reg, m_bad_next;

    logic [QW-1:0]  in_index;
    logic [SB-1:0]  in_symbol;
    logic [PW-1:0]  in_plen;
    logic [QW-1:0]  in_start;
    logic           in_acc;

    logic [TW-1:0]  tlen;
    logic [TW-1:0]  win;
    logic [TW-1:0]  pos;

    logic           text_we;
    logic [TAW-1:0] text_raddr;
    logic [SB-1:0]  text_rdata;
    logic           pat_we;
    logic [PAW-1:0] pat_raddr;
    logic [SB-1:0]  pat_rdata;
    logic           shift_we;
    logic [SAW-1:0] shift_waddr;
    logic [PW-1:0]  shift_wdata;
    logic [SAW-1:0] shift_raddr;
    logic [PW-1:0]  shift_rdata;

    assign in_index  = s_tdata[15:0];
    assign in_symbol = s_tdata[16 +: SB];
    assign in_plen   = s_tdata[30:24];
    assign in_start  = s_tdata[46:31];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign tlen = (text_length_reg > TW'(hps_pkg::TEXT_DEPTH)) ?
                  TW'(hps_pkg::TEXT_DEPTH) : text_length_reg;
    assign win  = k_reg + TW'(1) - TW'(plen_reg);
    assign pos  = win + TW'(j_reg);

    assign text_we = in_acc && (s_tuser == hps_pkg::REQ_TEXT) &&
                     ({1'b0, in_index} < TW'(hps_pkg::TEXT_DEPTH));
    assign pat_we  = in_acc && (s_tuser == hps_pkg::REQ_PATTERN) &&
                     (32'(in_index) < hps_pkg::MAX_PATTERN);

    always_comb begin
        text_raddr = (state_reg == S_CMP) ? TAW'(k_reg) : TAW'(pos);
        pat_raddr  = (state_reg == S_BUILD) ? PAW'(bld_idx_reg) : j_reg;
        shift_raddr = SAW'(text_rdata);
        shift_we    = 1'b0;
        shift_waddr = fill_reg;
        shift_wdata = plen_reg;
        if (state_reg == S_FILL) begin
            shift_we = 1'b1;
        end else if (state_reg == S_BUILD && bld_wr_reg) begin
            shift_we    = 1'b1;
            shift_waddr = SAW'(pat_rdata);
            shift_wdata = bld_val_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        plen_next     = plen_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        fill_next     = fill_reg;
        bld_idx_next  = bld_idx_reg;
        bld_wr_next   = 1'b0;
        bld_val_next  = bld_val_reg;
        rpos_next     = rpos_reg;
        rfound_next   = rfound_reg;
        rbad_next     = rbad_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_pos_next    = m_pos_reg;
        m_found_next  = m_found_reg;
        m_bad_next    = m_bad_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc && s_tuser == hps_pkg::REQ_SEARCH) begin
                    plen_next   = in_plen;
                    k_next      = TW'(in_start) + TW'(in_plen) - TW'(1);
                    j_next      = PAW'(in_plen - PW'(1));
                    fill_next   = '0;
                    rpos_next   = '0;
                    rfound_next = 1'b0;
                    rbad_next   = 1'b0;
                    if (in_plen == '0 || 32'(in_plen) > hps_pkg::MAX_PATTERN) begin
                        rbad_next  = 1'b1;
                        state_next = S_RES;
                    end else begin
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL: begin
                fill_next = fill_reg + SAW'(1);
                if (32'(fill_reg) == hps_pkg::SHIFT_N - 1) begin
                    bld_idx_next = '0;
                    state_next   = S_BUILD;
                end
            end
            S_BUILD: begin
                if ({1'b0, bld_idx_reg} + (PW+1)'(1) < {1'b0, plen_reg}) begin
                    bld_wr_next  = 1'b1;
                    bld_val_next = plen_reg - PW'(1) - bld_idx_reg;
                    bld_idx_next = bld_idx_reg + PW'(1);
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (k_reg < tlen && !win[TW-1]) begin
                    state_next = S_CMP;
                end else begin
                    state_next = S_RES;
                end
            end
            S_CMP: begin
                if (text_rdata == pat_rdata) begin
                    if (j_reg == '0) begin
                        rpos_next   = QW'(win);
                        rfound_next = 1'b1;
                        state_next  = S_RES;
                    end else begin
                        j_next     = j_reg - PAW'(1);
                        state_next = S_CHECK;
                    end
                end else begin
                    state_next = S_TK;
                end
            end
            S_TK: begin
                state_next = S_SH;
            end
            S_SH: begin
                k_next     = k_reg + TW'(shift_rdata);
                j_next     = PAW'(plen_reg - PW'(1));
                state_next = S_CHECK;
            end
            S_RES: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_pos_next    = rpos_reg;
                    m_found_next  = rfound_reg;
                    m_bad_next    = rbad_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_tvalid_reg    <= 1'b0;
            text_length_reg <= '0;
            bld_wr_reg      <= 1'b0;
            k_reg           <= '0;
            j_reg           <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            bld_wr_reg   <= bld_wr_next;
            k_reg        <= k_next;
            j_reg        <= j_next;
            if (cfg_valid && cfg_ready) begin
                text_length_reg <= cfg_data;
            end
        end
        plen_reg    <= plen_next;
        fill_reg    <= fill_next;
        bld_idx_reg <= bld_idx_next;
        bld_val_reg <= bld_val_next;
        rpos_reg    <= rpos_next;
        rfound_reg  <= rfound_next;
        rbad_reg    <= rbad_next;
        m_pos_reg   <= m_pos_next;
        m_found_reg <= m_found_next;
        m_bad_reg   <= m_bad_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_bad_reg, m_found_reg, m_pos_reg};

    hps_ram #(.WIDTH(SB), .DEPTH(hps_pkg::TEXT_DEPTH)) u_text_ram (
        .aclk  (aclk),
        .we    (text_we),
        .waddr (TAW'(in_index)),
        .wdata (in_symbol),
        .raddr (text_raddr),
        .rdata (text_rdata)
    );

    hps_ram #(.WIDTH(SB), .DEPTH(hps_pkg::MAX_PATTERN)) u_pat_ram (
        .aclk  (aclk),
        .we    (pat_we),
        .waddr (PAW'(in_index)),
        .wdata (in_symbol),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    hps_ram #(.WIDTH(PW), .DEPTH(hps_pkg::SHIFT_N)) u_shift_ram (
        .aclk  (aclk),
        .we    (shift_we),
        .waddr (shift_waddr),
        .wdata (shift_wdata),
        .raddr (shift_raddr),
        .rdata (shift_rdata)
    );

    a_bad_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_bad_reg) |-> (!m_found_reg && m_pos_reg == '0))
        else $error("bad length result carries a match");

    a_cmp_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> ($past(k_reg) < $past(tlen) && !$past(win[TW-1])))
        else $error("compare issued outside the text");

    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SH) |-> (shift_rdata != '0 && shift_rdata <= plen_reg))
        else $error("shift out of range");

endmodule
